### rtl/gtp_pkg.sv
// ---------------------------------------------------------------------------
// gtp_pkg - go-to-point controller shared types and constants
// widths of the cordic and square-root datapath, the arctangent table and
// the record that moves from cell to cell
// ---------------------------------------------------------------------------
package gtp_pkg;

   // cordic datapath
   localparam int CW         = 35;        // x and y, signed, scaled by 2^16
   localparam int ZW         = 28;        // angle in 2^-24 rad, signed
   localparam int ATAN_DEPTH = 24;
   localparam logic signed [ZW-1:0] HALF_PI = 28'sd26353589;

   // integer square root of gain^2 * dist^2
   localparam int RAD_W    = 54;
   localparam int SQ_STEPS = RAD_W / 2;
   localparam int ROOT_W   = SQ_STEPS;
   localparam int REM_W    = ROOT_W + 2;

   // distance test: 100 * d2 > 2^20 is d2 > 10485
   localparam logic [29:0] NEAR_D2   = 30'd10485;
   localparam logic [16:0] TURN_MIN  = 17'd820;
   localparam logic [ZW-1:0] Z_ROUND = ZW'(2048);

   // register indexes of the write port
   typedef enum logic [1:0] {
      REG_GOAL_X      = 2'd0,
      REG_GOAL_Y      = 2'd1,
      REG_SPEED_GAIN  = 2'd2,
      REG_SPEED_LIMIT = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic                     valid;
      logic                     far;
      logic signed [14:0]       hd;
      logic signed [CW-1:0]     x;
      logic signed [CW-1:0]     y;
      logic signed [ZW-1:0]     z;
      logic [REM_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
      logic [RAD_W-1:0]         rad;
   } cell_type;

   function automatic logic signed [ZW-1:0] atan_val(input int i);
      logic signed [ZW-1:0] v;
      unique case (i)
         0:  v = 28'sd13176795;
         1:  v = 28'sd7778716;
         2:  v = 28'sd4110060;
         3:  v = 28'sd2086331;
         4:  v = 28'sd1047214;
         5:  v = 28'sd524117;
         6:  v = 28'sd262123;
         7:  v = 28'sd131069;
         8:  v = 28'sd65536;
         9:  v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/gtp_cell.sv
// ---------------------------------------------------------------------------
// gtp_cell - one cell of the steering pipeline
// at most one cordic vectoring rotation and one square-root digit per cell
// ---------------------------------------------------------------------------
module gtp_cell #(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  gtp_pkg::cell_type up_data,
   output logic              up_ready,
   output gtp_pkg::cell_type dn_data,
   input  logic              dn_ready
);
   import gtp_pkg::*;

   cell_type             data_ff;
   cell_type             data_in;
   logic signed [CW-1:0] x_nx, y_nx;
   logic signed [ZW-1:0] z_nx;
   logic [REM_W-1:0]     rem_nx;
   logic [ROOT_W-1:0]    root_nx;

   assign up_ready = !data_ff.valid || dn_ready;
   assign dn_data  = data_ff;

   generate
      if (IDX < CORDIC_STAGES && IDX < ATAN_DEPTH) begin : g_rot
         logic signed [CW-1:0] xi, yi, xs, ys;
         always_comb begin
            xi = up_data.x;
            yi = up_data.y;
            xs = xi >>> IDX;
            ys = yi >>> IDX;
            if (yi > 0) begin
               x_nx = xi + ys;
               y_nx = yi - xs;
               z_nx = up_data.z + atan_val(IDX);
            end else begin
               x_nx = xi - ys;
               y_nx = yi + xs;
               z_nx = up_data.z - atan_val(IDX);
            end
         end
      end else begin : g_rot_pass
         assign x_nx = up_data.x;
         assign y_nx = up_data.y;
         assign z_nx = up_data.z;
      end

      if (IDX < SQ_STEPS) begin : g_sqrt
         localparam int SEL = 2 * (SQ_STEPS - 1 - IDX);
         logic [REM_W+1:0] rem_sh, trial;
         always_comb begin
            rem_sh = {up_data.rem, up_data.rad[SEL +: 2]};
            trial  = (REM_W+2)'({up_data.root, 2'b01});
            if (rem_sh >= trial) begin
               rem_nx  = REM_W'(rem_sh - trial);
               root_nx = {up_data.root[ROOT_W-2:0], 1'b1};
            end else begin
               rem_nx  = REM_W'(rem_sh);
               root_nx = {up_data.root[ROOT_W-2:0], 1'b0};
            end
         end
      end else begin : g_sqrt_pass
         assign rem_nx  = up_data.rem;
         assign root_nx = up_data.root;
      end
   endgenerate

   always_comb begin
      data_in      = up_data;
      data_in.x    = x_nx;
      data_in.y    = y_nx;
      data_in.z    = z_nx;
      data_in.rem  = rem_nx;
      data_in.root = root_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/go_to_point_steering_controller.sv
// ---------------------------------------------------------------------------
// go_to_point_steering_controller - proportional go-to-goal steering
// pose in, forward speed and turn rate out, through a chain of cordic and
// square-root cells
// ---------------------------------------------------------------------------
// Takes one pose transfer per cycle unless a stalled result side has backed
// up the chain, and returns one command per pose, in order. The path is
// three front stages (goal offset, squared distance with cordic
// pre-rotation, gain^2 * d2), 27 cells set by the 27 digits of the integer
// square root of a 54-bit radicand (the CORDIC_STAGES rotations share those
// cells), and one output register. Every stage has its own valid bit, so a
// stalled result only holds back as many stages as are full and bubbles
// squeeze out. Bearing error is atan2 to the goal minus heading, not
// wrapped. Within 0.1 m of the goal both outputs are zero; an error of
// 820/4096 rad or more turns in place at |error|; otherwise the robot drives
// at gain * distance capped at speed_limit. Write registers only while idle.
// ---------------------------------------------------------------------------
module go_to_point_steering_controller #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // pose stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x[13:0], pos_y[27:14], heading[42:28], zero pad
   // command stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // forward_speed[13:0], turn_rate[28:14], zero pad
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);
   import gtp_pkg::*;

   localparam int NCELL = (CORDIC_STAGES > SQ_STEPS) ? CORDIC_STAGES : SQ_STEPS;

   // configuration registers
   logic [13:0] goal_x_ff, goal_y_ff, limit_ff;
   logic [11:0] gain_ff;
   logic [23:0] gain2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= 14'd1024;
         goal_y_ff <= 14'd3072;
         gain_ff   <= 12'd256;
         limit_ff  <= 14'd2048;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_GOAL_X:      goal_x_ff <= csr_wdata;
            REG_GOAL_Y:      goal_y_ff <= csr_wdata;
            REG_SPEED_GAIN:  gain_ff   <= csr_wdata[11:0];
            REG_SPEED_LIMIT: limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // gain squared is registered from the gain register, for the stage 3 radicand
   always_ff @(posedge clock) begin
      gain2_ff <= gain_ff * gain_ff;
   end

   // ready ripples back from the output register through every stage
   logic f1_ready, f2_ready, f3_ready, out_ready;
   logic [NCELL:0] cell_ready;
   cell_type       cell_link [NCELL+1];

   // stage 1: offsets to the goal
   logic               f1_valid_ff;
   logic signed [14:0] dx_ff, dy_ff, hd1_ff;

   assign req_tready = f1_ready;
   assign f1_ready   = !f1_valid_ff || f2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (f1_ready) begin
         f1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_ready) begin
         dx_ff  <= $signed({1'b0, goal_x_ff}) - $signed({1'b0, req_tdata[13:0]});
         dy_ff  <= $signed({1'b0, goal_y_ff}) - $signed({1'b0, req_tdata[27:14]});
         hd1_ff <= $signed(req_tdata[42:28]);
      end
   end

   // stage 2: squared distance and quadrant pre-rotation
   logic                 f2_valid_ff;
   logic [29:0]          d2_ff;
   logic signed [CW-1:0] x2_ff, y2_ff;
   logic signed [ZW-1:0] z2_ff;
   logic signed [14:0]   hd2_ff;
   logic signed [29:0]   sq_x, sq_y;
   logic signed [CW-1:0] xe, ye, x2_in, y2_in;
   logic signed [ZW-1:0] z2_in;

   assign f2_ready = !f2_valid_ff || f3_ready;
   assign sq_x     = dx_ff * dx_ff;
   assign sq_y     = dy_ff * dy_ff;
   assign xe       = {{(CW-31){dx_ff[14]}}, dx_ff, 16'b0};
   assign ye       = {{(CW-31){dy_ff[14]}}, dy_ff, 16'b0};

   always_comb begin
      x2_in = xe;
      y2_in = ye;
      z2_in = '0;
      if (dx_ff < 0) begin
         if (dy_ff >= 0) begin
            x2_in = ye;
            y2_in = -xe;
            z2_in = HALF_PI;
         end else begin
            x2_in = -ye;
            y2_in = xe;
            z2_in = -HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (f2_ready) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f2_ready) begin
         d2_ff  <= $unsigned(sq_x) + $unsigned(sq_y);
         x2_ff  <= x2_in;
         y2_ff  <= y2_in;
         z2_ff  <= z2_in;
         hd2_ff <= hd1_ff;
      end
   end

   // stage 3: radicand and near-goal test, loads the head of the cell chain
   cell_type f3_ff;
   cell_type f3_in;

   assign f3_ready = !f3_ff.valid || cell_ready[0];

   always_comb begin
      f3_in.valid = f2_valid_ff;
      f3_in.far   = d2_ff > NEAR_D2;
      f3_in.hd    = hd2_ff;
      f3_in.x     = x2_ff;
      f3_in.y     = y2_ff;
      f3_in.z     = z2_ff;
      f3_in.rem   = '0;
      f3_in.root  = '0;
      f3_in.rad   = gain2_ff * d2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_ff.valid <= 1'b0;
      end else if (f3_ready) begin
         f3_ff <= f3_in;
      end
   end

   assign cell_link[0] = f3_ff;

   // the cell chain: rotation i and square-root digit i in cell i
   genvar gi;
   generate
      for (gi = 0; gi < NCELL; gi++) begin : g_cell
         gtp_cell #(
            .IDX           (gi),
            .CORDIC_STAGES (CORDIC_STAGES)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_data  (cell_link[gi]),
            .up_ready (cell_ready[gi]),
            .dn_data  (cell_link[gi+1]),
            .dn_ready (cell_ready[gi+1])
         );
      end
   endgenerate

   assign cell_ready[NCELL] = out_ready;

   // output stage: round the bearing, pick the steering case
   cell_type             tail;
   logic signed [ZW-1:0] z_sum;
   logic signed [15:0]   bearing;
   logic signed [16:0]   err;
   logic [16:0]          err_abs;
   logic [13:0]          speed_in, speed_ff;
   logic [14:0]          turn_in, turn_ff;
   logic                 rsp_valid_ff;

   assign tail    = cell_link[NCELL];
   assign z_sum   = tail.z + $signed(Z_ROUND);
   assign bearing = z_sum[ZW-1:12];
   assign err     = 17'(bearing) - 17'(tail.hd);
   assign err_abs = err[16] ? 17'(-err) : 17'(err);

   always_comb begin
      speed_in = '0;
      turn_in  = '0;
      if (tail.far) begin
         if (err_abs >= TURN_MIN) begin
            turn_in = err_abs[14:0];
         end else if (tail.root[ROOT_W-1:8] > (ROOT_W-8)'(limit_ff)) begin
            speed_in = limit_ff;
         end else begin
            speed_in = tail.root[21:8];
         end
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         speed_ff <= speed_in;
         turn_ff  <= turn_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, turn_ff, speed_ff};

`ifndef ASSERT_OFF
   // driving and turning never mix
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (speed_ff == '0 || turn_ff == '0))
      else $error("speed and turn both nonzero");

   // the speed cap holds
   a_speed_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> speed_ff <= limit_ff)
      else $error("forward speed above limit");

   // turning in place only for a large error
   a_turn_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && turn_ff != '0) |-> turn_ff >= TURN_MIN[14:0])
      else $error("turn rate below threshold");

   // the input side only blocks when the whole chain backs up from the output
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input blocked without output stall");
`endif

endmodule
